### rtl/mbd_pkg.sv
package mbd_pkg;

  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_W      = 8;
  localparam int unsigned SUM_W       = LANE_W + 1;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned HEIGHT_W    = 13;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 4'd1;

  typedef logic [LANES-1:0][SUM_W-1:0] mbd_pair_t;

  typedef struct packed {
    logic      is_write;
    logic      use_upper;
    logic [1:0] shift;
    logic      last;
    mbd_pair_t pair;
  } mbd_op_t;

endpackage

### rtl/mip_box_downsample_2x2.sv
// A request that completes a 2x2 block passes through the queue, the line-store stage and the output register.
// Throughput: one source pixel per cycle while the result side keeps taking requests.
// A four-entry queue between the position tracker and the line-store stage absorbs stalls.
// Reset (synchronous, active low) sets both dimensions to 1, clears positions and empties
// the queue and output register; the line store is not cleared and needs no clearing pass.
module mip_box_downsample_2x2 #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     in_source_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_averaged_pixel,
  output logic                            out_last_of_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mbd_pkg::*;

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned XW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned QW         = $bits(mbd_op_t) + XW;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  mbd_op_t          push_op, pop_op;
  logic [XW-1:0]    push_x, pop_x;
  logic [QW-1:0]    pop_data;

  mbd_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .XW       (XW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_pixel(in_source_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_op        (push_op),
    .push_x         (push_x)
  );

  mbd_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_op, push_x}),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  assign pop_op = pop_data[QW-1:XW];
  assign pop_x  = pop_data[XW-1:0];

  mbd_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .XW       (XW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_op            (pop_op),
    .pop_x             (pop_x),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_averaged_pixel(out_averaged_pixel),
    .out_last_of_level (out_last_of_level)
  );

endmodule

### rtl/mbd_front.sv
module mbd_front #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned XW        = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     in_source_pixel,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            push_valid,
  input  logic                            push_ready,
  output mbd_pkg::mbd_op_t                push_op,
  output logic [XW-1:0]                   push_x
);
  import mbd_pkg::*;

  localparam int unsigned W_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (W_W > CFG_DATA_W) ? W_W : CFG_DATA_W;

  logic [W_W-1:0]      width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [W_W-1:0]      col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [31:0]         held_r, held_nxt;

  logic                accept;
  logic                width_one, height_one;
  logic [W_W-1:0]      out_w, pair_limit, col_inc;
  logic [HEIGHT_W-1:0] out_h, row_limit, row_inc;
  logic                in_pair_cols, in_pair_rows;
  logic                have_pair, take_left, write_row, emit;
  mbd_op_t             op;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;

  assign width_one    = (width_r == W_W'(1));
  assign height_one   = (height_r == HEIGHT_W'(1));
  assign out_w        = width_one ? W_W'(1) : (width_r >> 1);
  assign out_h        = height_one ? HEIGHT_W'(1) : (height_r >> 1);
  assign pair_limit   = width_r & ~W_W'(1);
  assign row_limit    = height_r & ~HEIGHT_W'(1);
  assign in_pair_cols = (col_r < pair_limit);
  assign in_pair_rows = (row_r < row_limit);
  assign have_pair    = width_one || (in_pair_cols && col_r[0]);
  assign take_left    = !width_one && in_pair_cols && !col_r[0];
  assign write_row    = !height_one && in_pair_rows && !row_r[0];
  assign emit         = height_one || (in_pair_rows && row_r[0]);

  always_comb begin
    op           = '0;
    op.is_write  = write_row;
    op.use_upper = !height_one;
    op.shift     = {1'b0, !width_one} + {1'b0, !height_one};
    op.last      = ((col_r >> 1) == (out_w - W_W'(1))) &&
                   ((row_r >> 1) == (out_h - HEIGHT_W'(1)));
    for (int c = 0; c < LANES; c++) begin
      if (width_one) begin
        op.pair[c] = {1'b0, in_source_pixel[c*LANE_W +: LANE_W]};
      end else begin
        op.pair[c] = {1'b0, held_r[c*LANE_W +: LANE_W]} +
                     {1'b0, in_source_pixel[c*LANE_W +: LANE_W]};
      end
    end
  end

  assign push_op    = op;
  assign push_x     = XW'(col_r >> 1);
  assign push_valid = accept && have_pair && (write_row || emit);

  assign col_inc = col_r + W_W'(1);
  assign row_inc = row_r + HEIGHT_W'(1);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    held_nxt   = held_r;
    if (cfg_valid && (cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT)) begin
      col_nxt = '0;
      row_nxt = '0;
      if (cfg_index == REG_SOURCE_WIDTH) begin
        if (cfg_data == '0) begin
          width_nxt = W_W'(1);
        end else if (CMP_W'(cfg_data) > CMP_W'(MAX_WIDTH)) begin
          width_nxt = W_W'(MAX_WIDTH);
        end else begin
          width_nxt = W_W'(cfg_data);
        end
      end else begin
        if (cfg_data == '0) begin
          height_nxt = HEIGHT_W'(1);
        end else if (cfg_data > HEIGHT_W'(MAX_HEIGHT)) begin
          height_nxt = HEIGHT_W'(MAX_HEIGHT);
        end else begin
          height_nxt = cfg_data;
        end
      end
    end else if (accept) begin
      if (take_left) begin
        held_nxt = in_source_pixel;
      end
      if (col_inc >= width_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= height_r) ? '0 : row_inc;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= W_W'(1);
      height_r <= HEIGHT_W'(1);
      col_r    <= '0;
      row_r    <= '0;
      held_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

### rtl/mbd_queue.sv
module mbd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import mbd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/mbd_back.sv
module mbd_back #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned XW        = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  mbd_pkg::mbd_op_t pop_op,
  input  logic [XW-1:0]    pop_x,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_averaged_pixel,
  output logic             out_last_of_level
);
  import mbd_pkg::*;

  localparam int unsigned LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;

  mbd_pair_t   line_mem [LINE_DEPTH];
  mbd_pair_t   upper_r;
  mbd_op_t     s1_op_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_pixel_r;
  logic        out_last_r;
  logic [31:0] result;

  logic out_free, s1_move, pop, wr_en, s1_load;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign pop_ready = pop_op.is_write || !s1_valid_r || s1_move;
  assign pop       = pop_valid && pop_ready;
  assign wr_en     = pop && pop_op.is_write;
  assign s1_load   = pop && !pop_op.is_write;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[pop_x] <= pop_op.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      upper_r <= line_mem[pop_x];
      s1_op_r <= pop_op;
    end
  end

  always_comb begin
    logic [SUM_W:0] total;
    logic [SUM_W:0] scaled;
    result = '0;
    for (int c = 0; c < LANES; c++) begin
      total  = {1'b0, s1_op_r.pair[c]} +
               (s1_op_r.use_upper ? {1'b0, upper_r[c]} : '0);
      scaled = total >> s1_op_r.shift;
      result[c*LANE_W +: LANE_W] = scaled[LANE_W-1:0];
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pixel_r <= result;
      out_last_r  <= s1_op_r.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_averaged_pixel = out_pixel_r;
  assign out_last_of_level  = out_last_r;

endmodule

### rtl/mbd_checker.sv
module mbd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [31:0]                     out_averaged_pixel,
  input logic                            out_last_of_level,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);
  import mbd_pkg::*;

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_averaged_pixel) && $stable(out_last_of_level))
    else $error("stalled result changed");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration request refused");

  a_in_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_valid ##1 !in_valid && !out_valid ##1 !in_valid && !out_valid
    ##1 !in_valid && !out_valid ##1 !in_valid && !out_valid |-> in_ready)
    else $error("input refused with nothing in flight");

endmodule

bind mip_box_downsample_2x2 mbd_checker u_mbd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_averaged_pixel(out_averaged_pixel),
  .out_last_of_level (out_last_of_level),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready)
);
